>>> rtl/spder_pkg.sv
// shared types and constants for the start-pulse dual-edge byte receiver
// no dependencies; imported by every module of the block
package spder_pkg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_START   = 2'd1,
        PH_RECEIVE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_ABORT   = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        t_status    status;
    } t_result;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_TIMEOUT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] START_LOW_RESET    = 16'd190;
    localparam logic [CFG_DATA_W-1:0] BYTE_TIMEOUT_RESET = 16'd100;

    localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

>>> rtl/spder_core.sv
// receive state machine: edge detect, saturating tick counter, byte assembly
// depends on spder_pkg; result goes to the output buffer in the same cycle
module spder_core
    import spder_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic                  i_clock_level,
    input  logic                  i_data_level,
    output logic                  o_res_valid,
    output t_result               o_res
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_DATA_W) ? TICK_COUNT_WIDTH : CFG_DATA_W;
    localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = {TICK_COUNT_WIDTH{1'b1}};

    logic [CFG_DATA_W-1:0]       r_start_low;
    logic [CFG_DATA_W-1:0]       r_byte_timeout;
    t_phase                      r_phase, n_phase;
    logic                        r_prev_clk;
    logic [TICK_COUNT_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [2:0]                  r_bit_pos, n_bit_pos;
    logic [7:0]                  r_asm, n_asm;

    logic [TICK_COUNT_WIDTH-1:0] adv;
    logic [CMP_W-1:0]            adv_ext;
    logic                        start_done;
    logic                        timed_out;
    logic                        clk_edge;
    logic                        fall_edge;

    assign adv        = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign adv_ext    = CMP_W'(adv);
    assign start_done = adv_ext >= CMP_W'(r_start_low);
    assign timed_out  = adv_ext >= CMP_W'(r_byte_timeout);
    assign clk_edge   = i_clock_level != r_prev_clk;
    assign fall_edge  = !i_clock_level && r_prev_clk;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_START: begin
                if (start_done) begin
                    n_phase = PH_RECEIVE;
                end else if (i_clock_level) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_RECEIVE: begin
                if (timed_out) begin
                    n_phase = PH_IDLE;
                end else if (clk_edge && r_bit_pos == LAST_BIT) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = fall_edge ? PH_START : PH_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_elapsed   = r_elapsed;
        n_bit_pos   = r_bit_pos;
        n_asm       = r_asm;
        o_res_valid = 1'b0;
        o_res       = '{rx_byte: 8'd0, status: ST_BYTE};
        unique case (r_phase)
            PH_START: begin
                n_elapsed = adv;
                if (start_done) begin
                    n_elapsed = '0;
                    n_bit_pos = '0;
                    n_asm     = '0;
                end else if (i_clock_level) begin
                    o_res_valid = i_valid;
                    o_res.status = ST_ABORT;
                end
            end
            PH_RECEIVE: begin
                n_elapsed = adv;
                if (timed_out) begin
                    o_res_valid  = i_valid;
                    o_res.status = ST_TIMEOUT;
                end else if (clk_edge) begin
                    n_asm = r_asm | (8'(i_data_level) << r_bit_pos);
                    n_bit_pos = r_bit_pos + 3'd1;
                    if (r_bit_pos == LAST_BIT) begin
                        o_res_valid   = i_valid;
                        o_res.rx_byte = n_asm;
                    end
                end
            end
            default: begin
                if (fall_edge) begin
                    n_elapsed = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low    <= START_LOW_RESET;
            r_byte_timeout <= BYTE_TIMEOUT_RESET;
            r_phase        <= PH_IDLE;
            r_prev_clk     <= 1'b0;
            r_elapsed      <= '0;
            r_bit_pos      <= '0;
            r_asm          <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_START_LOW) begin
                r_start_low <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_BYTE_TIMEOUT) begin
                r_byte_timeout <= i_cfg_data;
            end
            if (i_valid) begin
                r_phase    <= n_phase;
                r_prev_clk <= i_clock_level;
                r_elapsed  <= n_elapsed;
                r_bit_pos  <= n_bit_pos;
                r_asm      <= n_asm;
            end
        end
    end

    // a result only comes from an accepted sample
    a_res_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_valid)
        else $error("result without accepted sample");

    // aborts and timeouts carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_BYTE) |-> o_res.rx_byte == 8'd0)
        else $error("nonzero byte on error status");

    // a completed byte sends the block back to idle
    a_byte_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_BYTE) |=> r_phase == PH_IDLE)
        else $error("phase not idle after byte");

endmodule

>>> rtl/spder_obuf.sv
// result register with one skid entry between the core and the output stream
// depends on spder_pkg
module spder_obuf
    import spder_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  logic    i_take
);

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_v || i_take;
    assign o_ready  = !r_skid_v;
    assign o_valid  = r_out_v;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full with empty output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push)
        else $error("push into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_take) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved forward");

endmodule

>>> rtl/start_pulse_dual_edge_byte_receiver_top.sv
// top level of the start-pulse dual-edge byte receiver
// depends on spder_pkg, spder_core and spder_obuf
//
// One stream transaction carries one sample of the clock line and the data
// line. In idle, a falling clock edge starts a tick counter; if clock stays
// low for start_low_ticks samples the receiver enters receive, and a rise
// before that yields an abort event. In receive every clock edge (rising or
// falling) stores the data sample as the next bit, LSB first; the eighth bit
// emits the byte, and byte_timeout_ticks samples without completing yield a
// timeout event. The counter is TICK_COUNT_WIDTH bits wide and saturates.
// The state update is one pass of logic between the accepted sample and the
// result register, so a sample is taken every cycle while o_s_tready is
// high. Results sit in an output register with one skid entry; o_s_tready
// drops only while that skid entry is occupied. Results are registered
// before they reach the output stream. Configuration writes are always
// ready and should be issued only while the receiver is idle.
module start_pulse_dual_edge_byte_receiver_top
    import spder_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,   // 0 start_low_ticks, 1 byte_timeout_ticks
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // sample stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,     // [0] clock_level, [1] data_level
    // result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [7:0]             o_m_tdata,     // [7:0] received_byte
    output logic [1:0]             o_m_tuser      // [1:0] event_status
);

    logic    s_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;

    // state machine sees each accepted sample once
    spder_core #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_accept),
        .i_clock_level(i_s_tdata[0]),
        .i_data_level (i_s_tdata[1]),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // result register plus skid entry decouples the two streams
    spder_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_valid),
        .i_res  (res),
        .o_ready(o_s_tready),
        .o_valid(o_m_tvalid),
        .o_res  (out_res),
        .i_take (i_m_tready)
    );

    assign o_m_tdata = out_res.rx_byte;
    assign o_m_tuser = 2'(out_res.status);

endmodule
